// ===== hw/rtl/blbr_pkg.sv =====
package blbr_pkg;

    localparam int unsigned BLBR_RAMP_TICKS_DEF = 2;

    // register map
    localparam logic [2:0] REG_RATIO_PERCENT   = 3'd0;
    localparam logic [2:0] REG_GAP_LIMIT_ONE   = 3'd1;
    localparam logic [2:0] REG_GAP_LIMIT_TWO   = 3'd2;
    localparam logic [2:0] REG_GAP_LIMIT_THREE = 3'd3;
    localparam logic [2:0] REG_STEP_ONE        = 3'd4;
    localparam logic [2:0] REG_STEP_TWO        = 3'd5;
    localparam logic [2:0] REG_STEP_THREE      = 3'd6;
    localparam logic [2:0] REG_STEP_FOUR       = 3'd7;

    // reset values
    localparam logic [6:0]  RST_RATIO_PERCENT   = 7'd100;
    localparam logic [15:0] RST_GAP_LIMIT_ONE   = 16'd64;
    localparam logic [15:0] RST_GAP_LIMIT_TWO   = 16'd256;
    localparam logic [15:0] RST_GAP_LIMIT_THREE = 16'd1024;
    localparam logic [15:0] RST_STEP_ONE        = 16'd1;
    localparam logic [15:0] RST_STEP_TWO        = 16'd4;
    localparam logic [15:0] RST_STEP_THREE      = 16'd16;
    localparam logic [15:0] RST_STEP_FOUR       = 16'd64;

    // divide by 100: q = (p * ceil(2^30 / 100)) >> 30, exact for p < 2^23
    localparam int          BLBR_RECIP_SHIFT = 30;
    localparam logic [23:0] BLBR_RECIP       = 24'd10737419;

    typedef struct packed {
        logic [6:0]  ratio_percent;
        logic [15:0] gap_limit_one;
        logic [15:0] gap_limit_two;
        logic [15:0] gap_limit_three;
        logic [15:0] step_one;
        logic [15:0] step_two;
        logic [15:0] step_three;
        logic [15:0] step_four;
    } t_cfg;

    typedef struct packed {
        logic [15:0] goal_level;
        logic [15:0] present_level;
        logic [15:0] step_size;
        logic        step_down;
        logic [7:0]  tick_count;
    } t_ramp;

    // writes caused by one tick: count, first level, second level
    typedef struct packed {
        logic [1:0]  cnt;
        logic [15:0] lvl0;
        logic [15:0] lvl1;
    } t_writes;

endpackage

// ===== hw/rtl/blbr_step.sv =====
module blbr_step
    import blbr_pkg::*;
#(
    parameter int unsigned RAMP_TICKS = BLBR_RAMP_TICKS_DEF
) (
    input  t_cfg        i_cfg,
    input  t_ramp       i_state,
    input  logic [15:0] i_target_level,
    input  logic        i_drive_accepts,
    output t_ramp       o_state,
    output t_writes     o_writes
);

    localparam logic [7:0] TICKS = 8'(RAMP_TICKS);

    logic [15:0] w_gap;

    assign w_gap = (i_target_level >= i_state.present_level)
                 ? (i_target_level - i_state.present_level)
                 : (i_state.present_level - i_target_level);

    always_comb begin
        t_ramp       s;
        logic        zero_wr;
        logic        ramp_wr;
        logic [15:0] lvl;
        logic [16:0] sum_up;
        logic [16:0] lim_dn;

        s       = i_state;
        zero_wr = 1'b0;
        ramp_wr = 1'b0;
        lvl     = '0;
        sum_up  = '0;
        lim_dn  = '0;

        if (i_target_level != s.goal_level) begin
            if (i_target_level == '0) begin
                zero_wr = 1'b1;
                if (i_drive_accepts) begin
                    s = '0;
                end
            end else begin
                if (w_gap <= i_cfg.gap_limit_one) begin
                    s.step_size = i_cfg.step_one;
                end else if (w_gap <= i_cfg.gap_limit_two) begin
                    s.step_size = i_cfg.step_two;
                end else if (w_gap <= i_cfg.gap_limit_three) begin
                    s.step_size = i_cfg.step_three;
                end else begin
                    s.step_size = i_cfg.step_four;
                end
                s.step_down  = i_target_level < s.present_level;
                s.goal_level = i_target_level;
                s.tick_count = TICKS;
            end
        end

        if (s.goal_level != s.present_level) begin
            if (s.tick_count >= TICKS) begin
                s.tick_count = '0;
                ramp_wr      = 1'b1;
                sum_up       = {1'b0, s.present_level} + {1'b0, s.step_size};
                lim_dn       = {1'b0, s.goal_level} + {1'b0, s.step_size};
                // clamp at the goal in either direction
                if (s.step_down) begin
                    if ({1'b0, s.present_level} <= lim_dn) begin
                        lvl = s.goal_level;
                    end else begin
                        lvl = s.present_level - s.step_size;
                    end
                end else begin
                    if (sum_up >= {1'b0, s.goal_level}) begin
                        lvl = s.goal_level;
                    end else begin
                        lvl = sum_up[15:0];
                    end
                end
                if (i_drive_accepts) begin
                    s.present_level = lvl;
                end
            end else begin
                s.tick_count = s.tick_count + 8'd1;
            end
        end

        o_state       = s;
        o_writes.cnt  = {zero_wr & ramp_wr, zero_wr ^ ramp_wr};
        o_writes.lvl0 = zero_wr ? 16'd0 : lvl;
        o_writes.lvl1 = lvl;
    end

endmodule

// ===== hw/rtl/blbr_scale.sv =====
module blbr_scale
    import blbr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [6:0]  i_ratio,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_level,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_drive_level,
    output logic [15:0] o_ramp_level,
    output logic        o_last
);

    logic        r_s1_valid;
    logic [22:0] r_s1_prod;
    logic [15:0] r_s1_level;
    logic        r_s1_last;
    logic        r_o_valid;
    logic [15:0] r_o_drive;
    logic [15:0] r_o_level;
    logic        r_o_last;

    logic        w_o_ready;
    logic        w_s1_ready;
    logic [22:0] w_prod;
    logic [46:0] w_mul;
    logic [16:0] w_quo;
    logic [15:0] w_drive;

    assign w_o_ready  = !r_o_valid || i_ready;
    assign w_s1_ready = !r_s1_valid || w_o_ready;
    assign o_ready    = w_s1_ready;

    assign w_prod  = {7'd0, i_level} * {16'd0, i_ratio};
    assign w_mul   = {24'd0, r_s1_prod} * {23'd0, BLBR_RECIP};
    assign w_quo   = w_mul[BLBR_RECIP_SHIFT +: 17];
    assign w_drive = w_quo[16] ? 16'hFFFF : w_quo[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_o_ready) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_valid) begin
            r_s1_prod  <= w_prod;
            r_s1_level <= i_level;
            r_s1_last  <= i_last;
        end
        if (w_o_ready && r_s1_valid) begin
            r_o_drive <= w_drive;
            r_o_level <= r_s1_level;
            r_o_last  <= r_s1_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_drive_level = r_o_drive;
    assign o_ramp_level  = r_o_level;
    assign o_last        = r_o_last;

endmodule

// ===== hw/rtl/backlight_brightness_ramp.sv =====
// Backlight brightness ramp: slew-rate limiter in front of a backlight driver.
// Input channel (i_in_valid / o_in_ready): one word per tick, a target level
// and a flag telling whether the driver takes a write this tick.
// Output channel (o_out_valid / i_out_ready): zero, one or two driver writes
// per tick, each with the scaled level, the raw ramp level and a last flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at once;
// the user writes only while the block is idle; the block does not enforce it.
// Pipeline: a tick's writes go through the write buffer, a register for the
// level * ratio product and the output register after the divide by 100.
// Throughput: one tick per cycle while the output is not stalled and it
// causes at most one write; a tick with two writes holds the input until the
// second drains, as the output moves one word per cycle from the write buffer.
// Stalls: the output pipeline holds its words while i_out_ready is low and
// input is taken as long as the write buffer can drain into it.
// Reset (synchronous, i_rst_n low): ramp state cleared, registers back to
// their defaults, all buffered writes dropped.
module backlight_brightness_ramp
    import blbr_pkg::*;
#(
    parameter int unsigned RAMP_TICKS = BLBR_RAMP_TICKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_target_level,
    input  logic        i_drive_accepts,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_drive_level,
    output logic [15:0] o_ramp_level,
    output logic        o_last_write
);

    // configuration and ramp state
    t_cfg        r_cfg;
    t_ramp       r_state;
    t_ramp       n_state;
    t_writes     w_writes;

    // write buffer: up to two writes of the last accepted tick
    logic [1:0]  r_pend_cnt;
    logic [15:0] r_pend_lvl0;
    logic [15:0] r_pend_lvl1;
    logic        r_pend_last0;

    logic        w_scale_ready;
    logic        w_pop;
    logic        w_accept;

    assign w_pop      = (r_pend_cnt != 2'd0) && w_scale_ready;
    assign o_in_ready = (r_pend_cnt == 2'd0) || ((r_pend_cnt == 2'd1) && w_pop);
    assign w_accept   = i_in_valid && o_in_ready;

    blbr_step #(
        .RAMP_TICKS (RAMP_TICKS)
    ) u_step (
        .i_cfg           (r_cfg),
        .i_state         (r_state),
        .i_target_level  (i_target_level),
        .i_drive_accepts (i_drive_accepts),
        .o_state         (n_state),
        .o_writes        (w_writes)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ratio_percent   <= RST_RATIO_PERCENT;
            r_cfg.gap_limit_one   <= RST_GAP_LIMIT_ONE;
            r_cfg.gap_limit_two   <= RST_GAP_LIMIT_TWO;
            r_cfg.gap_limit_three <= RST_GAP_LIMIT_THREE;
            r_cfg.step_one        <= RST_STEP_ONE;
            r_cfg.step_two        <= RST_STEP_TWO;
            r_cfg.step_three      <= RST_STEP_THREE;
            r_cfg.step_four       <= RST_STEP_FOUR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RATIO_PERCENT:   r_cfg.ratio_percent   <= i_cfg_data[6:0];
                REG_GAP_LIMIT_ONE:   r_cfg.gap_limit_one   <= i_cfg_data;
                REG_GAP_LIMIT_TWO:   r_cfg.gap_limit_two   <= i_cfg_data;
                REG_GAP_LIMIT_THREE: r_cfg.gap_limit_three <= i_cfg_data;
                REG_STEP_ONE:        r_cfg.step_one        <= i_cfg_data;
                REG_STEP_TWO:        r_cfg.step_two        <= i_cfg_data;
                REG_STEP_THREE:      r_cfg.step_three      <= i_cfg_data;
                REG_STEP_FOUR:       r_cfg.step_four       <= i_cfg_data;
            endcase
        end
    end

    // ramp state advances once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // write buffer: a new tick loads it whole, otherwise the head drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= 2'd0;
        end else if (w_accept) begin
            r_pend_cnt <= w_writes.cnt;
        end else if (w_pop) begin
            r_pend_cnt <= r_pend_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_lvl0  <= w_writes.lvl0;
            r_pend_lvl1  <= w_writes.lvl1;
            r_pend_last0 <= (w_writes.cnt == 2'd1);
        end else if (w_pop) begin
            r_pend_lvl0  <= r_pend_lvl1;
            r_pend_last0 <= 1'b1;
        end
    end

    // scaling pipeline and output register
    blbr_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ratio       (r_cfg.ratio_percent),
        .i_valid       (r_pend_cnt != 2'd0),
        .o_ready       (w_scale_ready),
        .i_level       (r_pend_lvl0),
        .i_last        (r_pend_last0),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_drive_level (o_drive_level),
        .o_ramp_level  (o_ramp_level),
        .o_last        (o_last_write)
    );

endmodule

// ===== sim/backlight_brightness_ramp_test.sv =====
`timescale 1ns / 1ps

module backlight_brightness_ramp_test;
    import blbr_pkg::*;

    localparam int unsigned RAMP_TICKS      = BLBR_RAMP_TICKS_DEF;
    localparam int unsigned PCT_BASE        = 100;
    localparam int          SETTLE_CYCLES   = 8;    // block holds at most four words, leave margin
    localparam int          PHASES          = 6;
    localparam int          TICKS_PER_PHASE = 92;
    localparam int          HOLD_CYCLES     = 300;  // long output stall, fills the block

    // one driver write as it leaves the block
    typedef struct packed {
        logic [15:0] drive_level;
        logic [15:0] ramp_level;
        logic        last_write;
    } t_write;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {CFG_RANDOM, CFG_LOW, CFG_HIGH} t_cfg_kind;

    // directed row: a tick (a = target, b[0] = accepts) or a register write
    // (a = index, b = data); chk rows carry the write count and the last write
    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] a;
        logic [15:0] b;
        logic        chk;
        logic [1:0]  n;
        logic [15:0] drv;
        logic [15:0] rmp;
    } t_plan_row;

    localparam int PLAN_ROWS = 25;
    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        // reset defaults: zero target with zero goal does nothing
        '{ROW_TICK, 16'd0,     16'd1, 1'b1, 2'd0, 16'd0,     16'd0},
        // full-scale target, big gap -> step_four, immediate first step
        '{ROW_TICK, 16'hFFFF,  16'd1, 1'b1, 2'd1, 16'd64,    16'd64},
        // same target again: tick counter runs, no write until it wraps
        '{ROW_TICK, 16'hFFFF,  16'd1, 1'b1, 2'd0, 16'd0,     16'd0},
        '{ROW_TICK, 16'hFFFF,  16'd1, 1'b1, 2'd0, 16'd0,     16'd0},
        '{ROW_TICK, 16'hFFFF,  16'd1, 1'b1, 2'd1, 16'd128,   16'd128},
        // switch-off refused by driver: goal kept, ramp continues
        '{ROW_TICK, 16'd0,     16'd0, 1'b1, 2'd1, 16'd0,     16'd0},
        // switch-off taken: ramp cleared
        '{ROW_TICK, 16'd0,     16'd1, 1'b1, 2'd1, 16'd0,     16'd0},
        // write refused: present level stays
        '{ROW_TICK, 16'd100,   16'd0, 1'b1, 2'd1, 16'd4,     16'd4},
        '{ROW_TICK, 16'd100,   16'd1, 1'b0, 2'd0, 16'd0,     16'd0},
        '{ROW_TICK, 16'd100,   16'd1, 1'b0, 2'd0, 16'd0,     16'd0},
        '{ROW_TICK, 16'd100,   16'd1, 1'b1, 2'd1, 16'd4,     16'd4},
        // ratio above 100 (upper data bits dropped), huge step
        '{ROW_CFG,  16'(REG_RATIO_PERCENT), 16'hFFFF, 1'b0, 2'd0, 16'd0, 16'd0},
        '{ROW_CFG,  16'(REG_STEP_FOUR),     16'hFFFF, 1'b0, 2'd0, 16'd0, 16'd0},
        // overshoot clamped at goal, scaled level saturates
        '{ROW_TICK, 16'hFFFF,  16'd1, 1'b1, 2'd1, 16'hFFFF,  16'hFFFF},
        // downward overshoot clamped at goal
        '{ROW_TICK, 16'd1,     16'd1, 1'b1, 2'd1, 16'd1,     16'd1},
        // zero step: level never moves
        '{ROW_CFG,  16'(REG_STEP_ONE),      16'd0,    1'b0, 2'd0, 16'd0, 16'd0},
        '{ROW_TICK, 16'd2,     16'd1, 1'b1, 2'd1, 16'd1,     16'd1},
        '{ROW_TICK, 16'd2,     16'd1, 1'b0, 2'd0, 16'd0,     16'd0},
        '{ROW_TICK, 16'd2,     16'd1, 1'b0, 2'd0, 16'd0,     16'd0},
        // refused switch-off plus a ramp step in the same tick: two writes
        '{ROW_TICK, 16'd0,     16'd0, 1'b1, 2'd2, 16'd1,     16'd1},
        // zero ratio: everything scales to 0
        '{ROW_CFG,  16'(REG_RATIO_PERCENT), 16'd0,    1'b0, 2'd0, 16'd0, 16'd0},
        '{ROW_TICK, 16'd0,     16'd1, 1'b1, 2'd1, 16'd0,     16'd0},
        '{ROW_TICK, 16'hFFFF,  16'd0, 1'b1, 2'd1, 16'd0,     16'hFFFF},
        '{ROW_TICK, 16'd7,     16'd1, 1'b0, 2'd0, 16'd0,     16'd0},
        '{ROW_TICK, 16'd7,     16'd1, 1'b0, 2'd0, 16'd0,     16'd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_target_level;
    logic        i_drive_accepts;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_drive_level;
    logic [15:0] o_ramp_level;
    logic        o_last_write;

    backlight_brightness_ramp #(
        .RAMP_TICKS(RAMP_TICKS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_target_level (i_target_level),
        .i_drive_accepts(i_drive_accepts),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_drive_level  (o_drive_level),
        .o_ramp_level   (o_ramp_level),
        .o_last_write   (o_last_write)
    );

    // shadow copy of the block: registers and ramp state
    t_cfg   cfg_shadow;
    t_ramp  ramp_shadow;
    t_write tick_writes [2];      // writes of the tick just predicted
    t_write pending_writes [$];   // writes still owed by the block

    int fail_count;       // output checker only
    int row_fail_count;   // directed table only
    int snd_idle_pct;
    int rdy_idle_pct;
    int hold_left;        // receiver only
    bit hold_taken;       // receiver only
    bit hold_req;         // stimulus only

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // level * ratio / 100, saturated to 16 bits
    function automatic logic [15:0] scaled(input logic [15:0] lvl);
        int unsigned p;
        p = (32'(lvl) * 32'(cfg_shadow.ratio_percent)) / PCT_BASE;
        return (p > 32'hFFFF) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic void cfg_store(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            REG_RATIO_PERCENT:   cfg_shadow.ratio_percent   = data[6:0];
            REG_GAP_LIMIT_ONE:   cfg_shadow.gap_limit_one   = data;
            REG_GAP_LIMIT_TWO:   cfg_shadow.gap_limit_two   = data;
            REG_GAP_LIMIT_THREE: cfg_shadow.gap_limit_three = data;
            REG_STEP_ONE:        cfg_shadow.step_one        = data;
            REG_STEP_TWO:        cfg_shadow.step_two        = data;
            REG_STEP_THREE:      cfg_shadow.step_three      = data;
            REG_STEP_FOUR:       cfg_shadow.step_four       = data;
            default: ;
        endcase
    endfunction

    // advance the shadow ramp by one tick, fill tick_writes, return the count
    function automatic int ramp_tick(input logic [15:0] tgt, input logic acc);
        int unsigned gap, lvl, goal, pres, stp;
        int n;
        n = 0;
        pres = ramp_shadow.present_level;
        if (tgt != ramp_shadow.goal_level) begin
            if (tgt == 16'd0) begin
                // switch-off goes out at once
                tick_writes[n] = '{scaled(16'd0), 16'd0, 1'b0};
                n++;
                if (acc)
                    ramp_shadow = '0;
            end else begin
                gap = (32'(tgt) >= pres) ? 32'(tgt) - pres : pres - 32'(tgt);
                if (gap <= cfg_shadow.gap_limit_one)
                    ramp_shadow.step_size = cfg_shadow.step_one;
                else if (gap <= cfg_shadow.gap_limit_two)
                    ramp_shadow.step_size = cfg_shadow.step_two;
                else if (gap <= cfg_shadow.gap_limit_three)
                    ramp_shadow.step_size = cfg_shadow.step_three;
                else
                    ramp_shadow.step_size = cfg_shadow.step_four;
                ramp_shadow.step_down  = (32'(tgt) < pres);
                ramp_shadow.goal_level = tgt;
                ramp_shadow.tick_count = 8'(RAMP_TICKS);  // step in this same tick
            end
        end
        if (ramp_shadow.goal_level != ramp_shadow.present_level) begin
            if (32'(ramp_shadow.tick_count) >= RAMP_TICKS) begin
                ramp_shadow.tick_count = 8'd0;
                goal = ramp_shadow.goal_level;
                pres = ramp_shadow.present_level;
                stp  = ramp_shadow.step_size;
                // clamp at the goal either way, even with a stale direction
                if (ramp_shadow.step_down)
                    lvl = (pres <= goal + stp) ? goal : pres - stp;
                else
                    lvl = (pres + stp >= goal) ? goal : pres + stp;
                tick_writes[n] = '{scaled(lvl[15:0]), lvl[15:0], 1'b0};
                n++;
                if (acc)
                    ramp_shadow.present_level = lvl[15:0];
            end else begin
                ramp_shadow.tick_count = ramp_shadow.tick_count + 8'd1;
            end
        end
        if (n > 0)
            tick_writes[n - 1].last_write = 1'b1;
        return n;
    endfunction

    // offer one tick word, wait for it to be taken, queue what it causes
    task automatic offer_tick(input logic [15:0] tgt, input logic acc, output int n);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_target_level  = tgt;
        i_drive_accepts = acc;
        do @(posedge i_clk); while (!o_in_ready);
        n = ramp_tick(tgt, acc);
        for (int k = 0; k < n; k++)
            pending_writes.push_back(tick_writes[k]);
    endtask

    // stop sending and let the block go quiet
    task automatic drain_out();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        cfg_store(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // full register set for one random phase
    task automatic load_phase_cfg(input t_cfg_kind kind);
        logic [15:0] lim1, lim2, lim3;
        case (kind)
            CFG_LOW: begin
                write_reg(REG_RATIO_PERCENT,   16'd0);
                write_reg(REG_GAP_LIMIT_ONE,   16'd0);
                write_reg(REG_GAP_LIMIT_TWO,   16'd0);
                write_reg(REG_GAP_LIMIT_THREE, 16'd0);
                write_reg(REG_STEP_ONE,        16'd1);
                write_reg(REG_STEP_TWO,        16'd1);
                write_reg(REG_STEP_THREE,      16'd1);
                write_reg(REG_STEP_FOUR,       16'd1);
            end
            CFG_HIGH: begin
                write_reg(REG_RATIO_PERCENT,   16'hFFFF);
                write_reg(REG_GAP_LIMIT_ONE,   16'hFFFF);
                write_reg(REG_GAP_LIMIT_TWO,   16'hFFFF);
                write_reg(REG_GAP_LIMIT_THREE, 16'hFFFF);
                write_reg(REG_STEP_ONE,        16'hFFFF);
                write_reg(REG_STEP_TWO,        16'hFFFF);
                write_reg(REG_STEP_THREE,      16'hFFFF);
                write_reg(REG_STEP_FOUR,       16'hFFFF);
            end
            default: begin
                // bands widen so every band gets used; step_one now and then zero
                lim1 = 16'($urandom_range(0, 200));
                lim2 = lim1 + 16'($urandom_range(0, 800));
                lim3 = lim2 + 16'($urandom_range(0, 4000));
                write_reg(REG_RATIO_PERCENT,   16'($urandom_range(0, 127)));
                write_reg(REG_GAP_LIMIT_ONE,   lim1);
                write_reg(REG_GAP_LIMIT_TWO,   lim2);
                write_reg(REG_GAP_LIMIT_THREE, lim3);
                write_reg(REG_STEP_ONE,
                          ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 40)));
                write_reg(REG_STEP_TWO,        16'($urandom_range(1, 120)));
                write_reg(REG_STEP_THREE,      16'($urandom_range(1, 400)));
                write_reg(REG_STEP_FOUR,       16'($urandom_range(1, 3000)));
            end
        endcase
    endtask

    // receiver: random ready, or a long hold-off once it is asked for
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(0, 99) >= rdy_idle_pct);
        end
    end

    // output check against the oldest owed write
    always @(posedge i_clk) begin
        t_write want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected write: drive_level %0d ramp_level %0d last_write %0b",
                       o_drive_level, o_ramp_level, o_last_write);
                fail_count++;
            end else begin
                want = pending_writes.pop_front();
                if (o_drive_level !== want.drive_level) begin
                    $error("drive_level: expected %0d, got %0d",
                           want.drive_level, o_drive_level);
                    fail_count++;
                end
                if (o_ramp_level !== want.ramp_level) begin
                    $error("ramp_level: expected %0d, got %0d",
                           want.ramp_level, o_ramp_level);
                    fail_count++;
                end
                if (o_last_write !== want.last_write) begin
                    $error("last_write: expected %0b, got %0b",
                           want.last_write, o_last_write);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int          n;
        int          run_left;
        int          pick;
        logic [15:0] run_target;
        logic [15:0] tgt;
        logic        acc;

        row_fail_count  = 0;
        hold_req        = 1'b0;
        snd_idle_pct    = 33;
        rdy_idle_pct    = 83;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_RATIO_PERCENT;
        i_cfg_data      = 16'd0;
        i_in_valid      = 1'b0;
        i_target_level  = 16'd0;
        i_drive_accepts = 1'b0;

        cfg_shadow = '{RST_RATIO_PERCENT, RST_GAP_LIMIT_ONE, RST_GAP_LIMIT_TWO,
                       RST_GAP_LIMIT_THREE, RST_STEP_ONE, RST_STEP_TWO,
                       RST_STEP_THREE, RST_STEP_FOUR};
        ramp_shadow = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (PLAN[r]) begin
            if (PLAN[r].kind == ROW_CFG) begin
                drain_out();
                write_reg(PLAN[r].a[2:0], PLAN[r].b);
            end else begin
                offer_tick(PLAN[r].a, PLAN[r].b[0], n);
                if (PLAN[r].chk) begin
                    if (n != int'(PLAN[r].n)) begin
                        $error("write count, row %0d: expected %0d, got %0d",
                               r, PLAN[r].n, n);
                        row_fail_count++;
                    end else if (n > 0 && (tick_writes[n - 1].drive_level != PLAN[r].drv ||
                                           tick_writes[n - 1].ramp_level != PLAN[r].rmp)) begin
                        $error("row %0d: expected drive_level %0d ramp_level %0d, got %0d %0d",
                               r, PLAN[r].drv, PLAN[r].rmp,
                               tick_writes[n - 1].drive_level,
                               tick_writes[n - 1].ramp_level);
                        row_fail_count++;
                    end
                end
            end
        end

        // random phases: idle pattern changes every two phases
        for (int p = 0; p < PHASES; p++) begin
            drain_out();
            case (p / 2)
                0:       begin snd_idle_pct = 33; rdy_idle_pct = 83; end
                1:       begin snd_idle_pct = 83; rdy_idle_pct = 33; end
                default: begin snd_idle_pct = 0;  rdy_idle_pct = 0;  end
            endcase
            load_phase_cfg((p == 1) ? CFG_LOW : (p == 3) ? CFG_HIGH : CFG_RANDOM);
            if (p == 4) begin
                // output stalls long while words keep coming
                @(posedge i_clk);
                hold_req = 1'b1;
            end
            run_left   = 0;
            run_target = 16'd0;
            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                // mostly steady targets held for a few ticks so the ramp runs
                if (run_left == 0) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10)
                        run_target = 16'd0;
                    else if (pick < 18)
                        run_target = 16'hFFFF;
                    else if (pick < 50)
                        run_target = 16'(int'(ramp_shadow.present_level) +
                                         int'($urandom_range(0, 600)) - 300);
                    else
                        run_target = 16'($urandom);
                    run_left = $urandom_range(1, 10);
                end
                tgt = run_target;
                if ($urandom_range(0, 99) < 8)
                    tgt = 16'($urandom);  // noise tick
                acc = ($urandom_range(0, 99) < 85);
                offer_tick(tgt, acc, n);
                run_left--;
            end
        end

        drain_out();
        if (fail_count == 0 && row_fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
